### rtl/mtt_pkg.sv
`default_nettype none

package mtt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_WIDTH = 32;
	localparam int IDX_W      = (NUM_TIMERS > 2) ? $clog2(NUM_TIMERS) : 1;
	localparam int SLOT_W     = 4;
	localparam int AMT_W      = 32;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [IDX_W-1:0]      idx_t;

	typedef enum logic [1:0] {
		MODE_TICK      = 2'd0,
		MODE_DECLARE   = 2'd1,
		MODE_UNDECLARE = 2'd2,
		MODE_NONE      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_DECLARED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_ZERO       = 3'd2,
		ST_REMOVED    = 3'd3,
		ST_NOT_IN_USE = 3'd4,
		ST_EXPIRED    = 3'd5,
		ST_IDLE_TICK  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_APPLY,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic found;
		idx_t idx;
	} first_t;

	// lowest set bit of a slot vector
	function automatic first_t find_first(input logic [NUM_TIMERS-1:0] v);
		first_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.idx   = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/mtt_tick_unit.sv
`default_nettype none

module mtt_tick_unit
	import mtt_pkg::*;
(
	input  wire logic  live,
	input  wire logic  tick,
	input  wire time_t amount,
	input  wire time_t rem,
	input  wire logic  any_in,
	input  wire time_t min_in,
	output logic       expire,
	output logic       wr_en,
	output time_t      new_rem,
	output logic       any_out,
	output time_t      min_out
);

	logic survive;

	always_comb begin
		expire  = live && tick && !(amount < rem);
		survive = live && !expire;
		new_rem = tick ? (rem - amount) : rem;
		wr_en   = survive && tick;
		any_out = any_in || survive;
		min_out = (survive && (!any_in || (new_rem < min_in))) ? new_rem : min_in;
	end

endmodule

`default_nettype wire

### rtl/multi_timer_table.sv
// Table of software timers kept against one elapsed-time input.
// Command channel: start with mode, amount, slot and event_tag is taken at
// a rising edge where start is high and busy is low. Mode tick subtracts
// amount from every live timer and expires those that run out; declare
// claims the lowest free slot; undeclare frees a slot.
// Result channel: done is high for one cycle per result, with status,
// result_slot, result_tag, next_valid, next_remaining and last. A tick that
// expires several timers gives one result per timer in rising slot order,
// on consecutive cycles; every other item gives a single result. last marks
// the final result of an item. The receiver cannot stall the block.
// Sequence: the command is applied, then the shared subtract/compare unit
// visits each slot in turn (memory read registered), then a drain state,
// then each result is registered into the output register.
// busy drops together with the final done, so the next item may be taken
// while that result is shown.
// Reset clears all in-use marks and the sequencer; no clearing pass.
`default_nettype none

module multi_timer_table
	import mtt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        mode,
	input  wire logic [AMT_W-1:0]  amount,
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic [7:0]        event_tag,
	output logic                   done,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      result_slot,
	output logic [7:0]             result_tag,
	output logic                   next_valid,
	output logic [31:0]            next_remaining,
	output logic                   last
);

	fsm_t state_q, state_d;

	mode_t               mode_q;
	time_t               amt_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [7:0]          tag_q;
	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic [NUM_TIMERS-1:0] in_use_q;
	logic [NUM_TIMERS-1:0] exp_q;
	idx_t                  idx_q;
	logic                  any_q;
	time_t                 min_q;

	time_t rem_mem [NUM_TIMERS];
	logic [7:0] tag_mem [NUM_TIMERS];

	logic  v_s1;
	idx_t  idx_s1;
	time_t rem_s1;

	logic        done_q;
	status_t     out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [7:0]  out_tag_q;
	logic        out_nv_q;
	logic [31:0] out_nr_q;
	logic        out_last_q;

	logic accept, apply_en, issue_en, emit_en, last_issue;

	first_t free_f, exp_f;
	logic   tick_mode, slot_ok, exp_emit, emit_last;
	logic [NUM_TIMERS-1:0] exp_rest;

	logic  u_expire, u_wr, u_any;
	time_t u_rem, u_min;

	logic  mem_we;
	idx_t  mem_wa;
	time_t mem_wd;
	logic  tag_we;

	assign accept     = start && (state_q == FSM_IDLE);
	assign busy       = (state_q != FSM_IDLE);
	assign last_issue = (idx_q == IDX_W'(NUM_TIMERS - 1));
	assign tick_mode  = (mode_q == MODE_TICK);
	assign free_f     = find_first(~in_use_q);
	assign exp_f      = find_first(exp_q);
	assign slot_ok    = (32'(slot_q) < 32'(NUM_TIMERS));

	always_comb begin
		exp_rest = exp_q;
		exp_rest[exp_f.idx] = 1'b0;
	end

	assign exp_emit  = tick_mode && exp_f.found;
	assign emit_last = !exp_emit || (exp_rest == '0);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		apply_en = 1'b0;
		issue_en = 1'b0;
		emit_en  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (start) state_d = FSM_APPLY;
			end
			FSM_APPLY: begin
				apply_en = 1'b1;
				state_d  = FSM_SCAN;
			end
			FSM_SCAN: begin
				issue_en = 1'b1;
				if (last_issue) state_d = FSM_DRAIN;
			end
			FSM_DRAIN: begin
				state_d = FSM_EMIT;
			end
			FSM_EMIT: begin
				emit_en = 1'b1;
				if (emit_last) state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	mtt_tick_unit u_unit (
		.live    (v_s1 && in_use_q[idx_s1]),
		.tick    (tick_mode),
		.amount  (amt_q),
		.rem     (rem_s1),
		.any_in  (any_q),
		.min_in  (min_q),
		.expire  (u_expire),
		.wr_en   (u_wr),
		.new_rem (u_rem),
		.any_out (u_any),
		.min_out (u_min)
	);

	// command capture and per-item bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			amt_q  <= TIME_WIDTH'(amount);
			slot_q <= slot;
			tag_q  <= event_tag;
		end
		if (apply_en) begin
			res_slot_q <= '0;
			case (mode_q)
				MODE_TICK: res_status_q <= ST_IDLE_TICK;
				MODE_DECLARE: begin
					if (amt_q == '0) begin
						res_status_q <= ST_ZERO;
					end else if (!free_f.found) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_DECLARED;
						res_slot_q   <= SLOT_W'(free_f.idx);
					end
				end
				MODE_UNDECLARE: begin
					res_slot_q   <= slot_q;
					res_status_q <= (slot_ok && in_use_q[IDX_W'(slot_q)]) ?
						ST_REMOVED : ST_NOT_IN_USE;
				end
				default: res_status_q <= ST_IDLE_TICK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			exp_q    <= '0;
			idx_q    <= '0;
			any_q    <= 1'b0;
			v_s1     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1   <= issue_en;
			done_q <= emit_en;
			if (apply_en) begin
				exp_q <= '0;
				idx_q <= '0;
				any_q <= 1'b0;
				if (mode_q == MODE_DECLARE && amt_q != '0 && free_f.found) begin
					in_use_q[free_f.idx] <= 1'b1;
				end
				if (mode_q == MODE_UNDECLARE && slot_ok) begin
					in_use_q[IDX_W'(slot_q)] <= 1'b0;
				end
			end
			if (issue_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (v_s1) begin
				any_q <= u_any;
				if (u_expire) begin
					in_use_q[idx_s1] <= 1'b0;
					exp_q[idx_s1]    <= 1'b1;
				end
			end
			if (emit_en && exp_emit) begin
				exp_q <= exp_rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			min_q <= u_min;
		end
		if (issue_en) begin
			idx_s1 <= idx_q;
		end
	end

	// remaining-time and tag stores
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = u_rem;
		tag_we = 1'b0;
		if (apply_en) begin
			mem_wa = free_f.idx;
			mem_wd = amt_q;
			if (mode_q == MODE_DECLARE && amt_q != '0 && free_f.found) begin
				mem_we = 1'b1;
				tag_we = 1'b1;
			end
		end else if (v_s1 && u_wr) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rem_mem[mem_wa] <= mem_wd;
		end
		if (issue_en) begin
			rem_s1 <= rem_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[mem_wa] <= tag_q;
		end
		if (emit_en) begin
			out_tag_q <= exp_emit ? tag_mem[exp_f.idx] : 8'd0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_status_q <= exp_emit ? ST_EXPIRED : res_status_q;
			out_slot_q   <= exp_emit ? SLOT_W'(exp_f.idx) : res_slot_q;
			out_nv_q     <= any_q;
			out_nr_q     <= any_q ? 32'(min_q) : 32'd0;
			out_last_q   <= emit_last;
		end
	end

	assign done           = done_q;
	assign status         = out_status_q;
	assign result_slot    = out_slot_q;
	assign result_tag     = out_tag_q;
	assign next_valid     = out_nv_q;
	assign next_remaining = out_nr_q;
	assign last           = out_last_q;

	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == FSM_EMIT))
		else $error("result without emit");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy)
		else $error("busy after final result");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("gap inside result burst");

	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !v_s1)
		else $error("scan stage active while idle");

	a_exp_tick: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !tick_mode && state_q != FSM_APPLY |-> exp_q == '0)
		else $error("expiry outside tick");

endmodule

`default_nettype wire
